### src/partition_fit_allocator_defines.svh
// Assertion macros for the partition fit allocator.
// Each macro expects clk and rst_n in scope.
`ifndef PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define PFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PFA_ASSERT(label, prop, msg)

`define PFA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### src/pfa_pkg.sv
package pfa_pkg;

  localparam int SIZE_W    = 32;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int POL_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  localparam logic [POL_W-1:0] POL_NEXT  = 2'd0;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd1;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'd1;

  localparam logic [POL_W-1:0] POLICY_RST = POL_FIRST;
  localparam logic [CNT_W-1:0] COUNT_RST  = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } pfa_state_t;

endpackage

### src/pfa_req_if.sv
interface pfa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [pfa_pkg::IDX_W-1:0]   block_index;
  logic [pfa_pkg::SIZE_W-1:0]  size_value;
  logic                        batch_end;

  modport source (output valid, opcode, block_index, size_value, batch_end, input ready);
  modport sink   (input valid, opcode, block_index, size_value, batch_end, output ready);
endinterface

### src/pfa_res_if.sv
interface pfa_res_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [pfa_pkg::IDX_W-1:0]   chosen_block;
  logic [pfa_pkg::SIZE_W-1:0]  remaining;

  modport source (output valid, granted, chosen_block, remaining, input ready);
  modport sink   (input valid, granted, chosen_block, remaining, output ready);
endinterface

### src/pfa_cfg_if.sv
interface pfa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfa_pkg::CFG_IDX_W-1:0]   index;
  logic [pfa_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/partition_fit_allocator.sv
// Partition fit allocator: a table of free sizes answering allocation requests.
// in_if carries one beat per item: a load (opcode 0) writes one entry's free
// size, a request (opcode 1) searches the first block_count entries (at most BLOCKS) by policy.
// out_if returns exactly one beat per item: granted, chosen_block, remaining.
// cfg_if writes policy (index 0) and block_count (index 1); it is always ready.
// It is to be written only while no item is in flight; the block itself does not enforce this.
// A load, or a request with block_count 0, passes the done state on its way to
// the output register. A request passes the scan state, a write-back on a grant
// and the done state; next fit first passes the prep state, which wraps a stale
// pointer that lies past the count. Best fit reads every entry, since the winner
// is known only after the last entry. First and next fit stop at the first hit.
// The free table is one memory with a single registered read port, read one
// entry per cycle, which sets the rate.
// One item is in work at a time; the next is accepted once the result sits in
// the output register, so a stalled receiver holds at most one finished beat
// plus one item waiting in the done state.
// Reset: policy first fit, block_count 16, next-fit pointer 0, output empty.
// Table contents are undefined until loaded.
module partition_fit_allocator #(
  parameter int BLOCKS = 16
) (
  input logic     clk,
  input logic     rst_n,
  pfa_req_if.sink   in_if,
  pfa_res_if.source out_if,
  pfa_cfg_if.sink   cfg_if
);
  import pfa_pkg::*;
  `include "partition_fit_allocator_defines.svh"

  localparam int AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  logic [SIZE_W-1:0] mem [BLOCKS];

  pfa_state_t        state_r, state_nxt;
  logic [POL_W-1:0]  policy_r, policy_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  np_r, np_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pend_r, pend_nxt;
  logic              found_r, found_nxt;

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              bend_r, bend_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  issue_j_r, issue_j_nxt;
  logic [CNT_W-1:0]  pend_k_r, pend_k_nxt;
  logic [CNT_W-1:0]  found_k_r, found_k_nxt;
  logic [SIZE_W-1:0] found_val_r, found_val_nxt;
  logic              res_granted_r, res_granted_nxt;
  logic [IDX_W-1:0]  res_block_r, res_block_nxt;
  logic [SIZE_W-1:0] res_remain_r, res_remain_nxt;
  logic              out_granted_r;
  logic [IDX_W-1:0]  out_block_r;
  logic [SIZE_W-1:0] out_remain_r;
  logic [SIZE_W-1:0] rd_data_r;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [SIZE_W-1:0] mem_wdata;
  logic              out_load;
  logic [CNT_W-1:0]  n_act;
  logic              fits, better, hit;

  assign n_act  = (32'(count_r) > BLOCKS) ? CNT_W'(BLOCKS) : count_r;
  assign fits   = rd_data_r >= size_r;
  assign better = !found_r || (rd_data_r < found_val_r);
  assign hit    = pend_r && fits && ((policy_r == POL_BEST) ? better : 1'b1);

  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.granted      = out_granted_r;
  assign out_if.chosen_block = out_block_r;
  assign out_if.remaining    = out_remain_r;

  always_comb begin
    state_nxt       = state_r;
    policy_nxt      = policy_r;
    count_nxt       = count_r;
    np_nxt          = np_r;
    pend_nxt        = pend_r;
    found_nxt       = found_r;
    size_nxt        = size_r;
    bend_nxt        = bend_r;
    n_nxt           = n_r;
    k_nxt           = k_r;
    issue_j_nxt     = issue_j_r;
    pend_k_nxt      = pend_k_r;
    found_k_nxt     = found_k_r;
    found_val_nxt   = found_val_r;
    res_granted_nxt = res_granted_r;
    res_block_nxt   = res_block_r;
    res_remain_nxt  = res_remain_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    out_load        = 1'b0;
    in_if.ready     = 1'b0;

    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_POLICY: policy_nxt = cfg_if.data[POL_W-1:0];
        CFG_COUNT:  count_nxt  = cfg_if.data[CNT_W-1:0];
        default:    ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          size_nxt    = in_if.size_value;
          bend_nxt    = in_if.batch_end;
          n_nxt       = n_act;
          issue_j_nxt = '0;
          pend_nxt    = 1'b0;
          found_nxt   = 1'b0;
          k_nxt       = np_r;
          if (in_if.opcode == OP_LOAD) begin
            res_granted_nxt = 1'b0;
            res_block_nxt   = in_if.block_index;
            np_nxt          = '0;
            if (32'(in_if.block_index) < BLOCKS) begin
              mem_we         = 1'b1;
              mem_waddr      = AW'(in_if.block_index);
              mem_wdata      = in_if.size_value;
              res_remain_nxt = in_if.size_value;
            end else begin
              res_remain_nxt = '0;
            end
            state_nxt = ST_DONE;
          end else if (n_act == '0) begin
            res_granted_nxt = 1'b0;
            res_block_nxt   = '0;
            res_remain_nxt  = '0;
            if (in_if.batch_end) np_nxt = '0;
            state_nxt = ST_DONE;
          end else if (policy_r == POL_NEXT) begin
            state_nxt = ST_PREP;
          end else begin
            k_nxt     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_PREP: begin
        // wrap a stale pointer back into the active range
        if (k_r >= n_r) begin
          k_nxt = k_r - n_r;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_j_r < n_r) begin
          mem_re      = 1'b1;
          mem_raddr   = AW'(k_r);
          k_nxt       = (k_r == n_r - 5'd1) ? '0 : k_r + 5'd1;
          issue_j_nxt = issue_j_r + 5'd1;
          pend_nxt    = 1'b1;
          pend_k_nxt  = k_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (hit) begin
          found_nxt     = 1'b1;
          found_k_nxt   = pend_k_r;
          found_val_nxt = rd_data_r;
          if (policy_r != POL_BEST) state_nxt = ST_WRITE;
        end else if (issue_j_r == n_r && !pend_r) begin
          if (found_r) begin
            state_nxt = ST_WRITE;
          end else begin
            res_granted_nxt = 1'b0;
            res_block_nxt   = '0;
            res_remain_nxt  = '0;
            if (bend_r) np_nxt = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        mem_we          = 1'b1;
        mem_waddr       = AW'(found_k_r);
        mem_wdata       = found_val_r - size_r;
        res_granted_nxt = 1'b1;
        res_block_nxt   = found_k_r[IDX_W-1:0];
        res_remain_nxt  = found_val_r - size_r;
        if (policy_r == POL_NEXT) np_nxt = found_k_r;
        if (bend_r) np_nxt = '0;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= POLICY_RST;
      count_r     <= COUNT_RST;
      np_r        <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      count_r     <= count_nxt;
      np_r        <= np_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r        <= size_nxt;
    bend_r        <= bend_nxt;
    n_r           <= n_nxt;
    k_r           <= k_nxt;
    issue_j_r     <= issue_j_nxt;
    pend_k_r      <= pend_k_nxt;
    found_k_r     <= found_k_nxt;
    found_val_r   <= found_val_nxt;
    res_granted_r <= res_granted_nxt;
    res_block_r   <= res_block_nxt;
    res_remain_r  <= res_remain_nxt;
    if (out_load) begin
      out_granted_r <= res_granted_r;
      out_block_r   <= res_block_r;
      out_remain_r  <= res_remain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  `PFA_ASSERT(a_rw_excl, !(mem_we && mem_re), "table read and write in the same cycle")
  `PFA_ASSERT(a_write_found, (state_r == ST_WRITE) |-> found_r, "write-back without a hit")
  `PFA_ASSERT(a_scan_range, (state_r == ST_SCAN && issue_j_r < n_r) |-> (k_r < n_r),
              "scan index out of range")
  `PFA_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE),
              "result beat without a finished item")
  `PFA_ASSERT_NEXT(a_done_drain, state_r == ST_DONE && (!out_valid_r || out_if.ready),
                   state_r == ST_IDLE && out_valid_r, "finished result not moved to output")

endmodule
